// ===== rtl/keypad_scan_code_lock_assert.svh =====
// assertion macros for the keypad code lock rtl
`ifndef KEYPAD_SCAN_CODE_LOCK_ASSERT_SVH
`define KEYPAD_SCAN_CODE_LOCK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define KSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define KSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/ksl_pkg.sv =====
// ----------------------------------------------------------------------------
// ksl_pkg
// Types, constants and the key map of the keypad scanner and code lock.
// ----------------------------------------------------------------------------
package ksl_pkg;

    localparam int unsigned ROWS      = 4;
    localparam int unsigned CODE_LEN  = 4;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [31:0] PASSCODE_RESET = 32'h3132_3334;
    localparam logic [2:0]  COUNT_FULL     = 3'd4;
    localparam logic [2:0]  COUNT_LAST     = 3'd3;

    typedef logic [7:0] t_char;
    typedef logic [3:0] t_rows;
    typedef logic [1:0] t_col;
    typedef logic [1:0] t_row_idx;
    typedef logic [2:0] t_count;

    // event handed from the scanner to the lock
    typedef struct packed {
        logic [3:0] column_drive;
        logic       key_valid;
        t_char      key_char;
    } t_scan_evt;

    // character of the key at a column and row
    function automatic t_char key_map(input t_col col, input t_row_idx row);
        t_char ch;
        case ({col, row})
            4'h0:    ch = "1";
            4'h1:    ch = "4";
            4'h2:    ch = "7";
            4'h3:    ch = "0";
            4'h4:    ch = "2";
            4'h5:    ch = "5";
            4'h6:    ch = "8";
            4'h7:    ch = "F";
            4'h8:    ch = "3";
            4'h9:    ch = "6";
            4'hA:    ch = "9";
            4'hB:    ch = "E";
            4'hC:    ch = "A";
            4'hD:    ch = "B";
            4'hE:    ch = "C";
            default: ch = "D";
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/ksl_if.sv =====
// ----------------------------------------------------------------------------
// ksl_if
// Valid/ready channels of the keypad code lock: row samples in, results out.
// ----------------------------------------------------------------------------

// row sample channel
interface ksl_row_if;
    logic       valid;
    logic       ready;
    logic [3:0] row_lines;

    modport source (output valid, output row_lines, input ready);
    modport sink   (input valid, input row_lines, output ready);
endinterface

// result channel
interface ksl_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] column_drive;
    logic       key_valid;
    logic [7:0] key_char;
    logic [2:0] entered_count;
    logic       check_done;
    logic       access_granted;

    modport source (output valid, output column_drive, output key_valid,
                    output key_char, output entered_count, output check_done,
                    output access_granted, input ready);
    modport sink   (input valid, input column_drive, input key_valid,
                    input key_char, input entered_count, input check_done,
                    input access_granted, output ready);
endinterface

// ===== rtl/ksl_scan.sv =====
// ----------------------------------------------------------------------------
// ksl_scan
// Front end: walks the columns, picks the lowest pressed row, waits for
// release and turns each row sample into a scan event.
// ----------------------------------------------------------------------------
module ksl_scan import ksl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ksl_row_if.sink      i_row,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_scan_evt    o_evt
);

    typedef enum logic {
        ST_SCAN,
        ST_HOLD
    } t_state;

    t_state   r_state, n_state;
    t_col     r_col, n_col;
    t_row_idx r_held, n_held;

    logic     fire;
    logic     found;
    t_row_idx low_row;

    assign i_row.ready = i_q_ready;
    assign fire        = i_row.valid && i_q_ready;
    assign o_push      = i_row.valid;

    // lowest pressed row
    always_comb begin
        found   = 1'b0;
        low_row = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            if (!i_row.row_lines[r]) begin
                found   = 1'b1;
                low_row = t_row_idx'(r);
            end
        end
    end

    // next scan state and the event for this sample
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_held  = r_held;
        o_evt   = '0;
        case (r_state)
            ST_HOLD: begin
                if (i_row.row_lines[r_held]) begin
                    n_state = ST_SCAN;
                    n_col   = r_col + t_col'(1);
                end
            end
            ST_SCAN: begin
                if (!found) begin
                    n_col = r_col + t_col'(1);
                end else begin
                    n_state         = ST_HOLD;
                    n_held          = low_row;
                    o_evt.key_valid = 1'b1;
                    o_evt.key_char  = key_map(r_col, low_row);
                end
            end
            default: n_state = ST_SCAN;
        endcase
        o_evt.column_drive = ~(4'b0001 << n_col);
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SCAN;
            r_col   <= '0;
            r_held  <= '0;
        end else if (fire) begin
            r_state <= n_state;
            r_col   <= n_col;
            r_held  <= n_held;
        end
    end

endmodule

// ===== rtl/ksl_queue.sv =====
// ----------------------------------------------------------------------------
// ksl_queue
// Short event queue between the scanner and the lock.
// ----------------------------------------------------------------------------
module ksl_queue import ksl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_scan_evt    i_evt,
    output logic         o_ready,
    output logic         o_valid,
    output t_scan_evt    o_evt,
    input  logic         i_pop
);

    t_scan_evt             r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]    r_cnt;

    logic do_push, do_pop;

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_evt;
        end
    end

endmodule

// ===== rtl/ksl_lock.sv =====
// ----------------------------------------------------------------------------
// ksl_lock
// Back end: collects keys, compares four of them with the passcode and
// holds the result item in an output register.
// ----------------------------------------------------------------------------
module ksl_lock import ksl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data,
    input  logic         i_evt_valid,
    input  t_scan_evt    i_evt,
    output logic         o_pop,
    ksl_res_if.source    o_res
);

    // the fourth key is compared straight from the event, so three entries
    t_char       r_entry [CODE_LEN-1];
    t_count      r_count, n_count;
    logic        r_access, n_access;
    logic [31:0] r_pass;
    logic        r_out_valid;
    logic        n_done;

    logic [3:0]  r_out_col;
    logic        r_out_kv;
    t_char       r_out_char;
    t_count      r_out_count;
    logic        r_out_done;

    assign o_pop = i_evt_valid && (!r_out_valid || o_res.ready);

    // key count, comparison and access flag
    always_comb begin
        n_count  = r_count;
        n_access = r_access;
        n_done   = 1'b0;
        if (i_evt.key_valid) begin
            if (r_count >= COUNT_FULL) begin
                n_count = 3'd1;
            end else begin
                n_count = r_count + 3'd1;
                if (r_count == COUNT_LAST) begin
                    n_done   = 1'b1;
                    n_access = ({r_entry[0], r_entry[1], r_entry[2], i_evt.key_char}
                                == r_pass);
                end
            end
        end
    end

    // control state and passcode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_access    <= 1'b0;
            r_pass      <= PASSCODE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pass <= i_cfg_wr_data;
            end
            if (o_pop) begin
                r_count     <= n_count;
                r_access    <= n_access;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // entry buffer and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_evt.key_valid) begin
                if (r_count >= COUNT_FULL) begin
                    r_entry[0] <= i_evt.key_char;
                end else if (r_count < COUNT_LAST) begin
                    r_entry[r_count[1:0]] <= i_evt.key_char;
                end
            end
            r_out_col   <= i_evt.column_drive;
            r_out_kv    <= i_evt.key_valid;
            r_out_char  <= i_evt.key_char;
            r_out_count <= n_count;
            r_out_done  <= n_done;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.column_drive   = r_out_col;
    assign o_res.key_valid      = r_out_kv;
    assign o_res.key_char       = r_out_char;
    assign o_res.entered_count  = r_out_count;
    assign o_res.check_done     = r_out_done;
    assign o_res.access_granted = r_access;

endmodule

// ===== rtl/keypad_scan_code_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_code_lock
// 4x4 matrix keypad scanner with a four-key code lock.
// ----------------------------------------------------------------------------
// Each row sample item yields exactly one result item, which carries the
// column pattern to drive for the next sample. The block takes one item per
// clock while input ready is high; its result is registered in the
// scanner-to-lock event queue and then in the result register. A stalled
// output side fills the two-entry queue before input ready drops. The
// passcode register is written directly and is used at the next comparison.
// ----------------------------------------------------------------------------
`include "keypad_scan_code_lock_assert.svh"

module keypad_scan_code_lock import ksl_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ksl_row_if.sink      i_row,
    ksl_res_if.source    o_res,
    input  logic         i_cfg_wr_en,
    input  logic [31:0]  i_cfg_wr_data
);

    logic      push, q_ready, q_valid, pop;
    t_scan_evt scan_evt, q_evt;

    // front end: scanner
    ksl_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (i_row),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_evt     (scan_evt)
    );

    // event queue
    ksl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (scan_evt),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_evt   (q_evt),
        .i_pop   (pop)
    );

    // back end: code lock
    ksl_lock u_lock (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_evt_valid   (q_valid),
        .i_evt         (q_evt),
        .o_pop         (pop),
        .o_res         (o_res)
    );

    // checks
    `KSL_ASSERT_IMP(a_done_at_four, i_clk, i_rst_n, o_res.valid && o_res.check_done, o_res.key_valid && (o_res.entered_count == COUNT_FULL))
    `KSL_ASSERT_IMP(a_no_key_no_char, i_clk, i_rst_n, o_res.valid && !o_res.key_valid, (o_res.key_char == 8'd0) && !o_res.check_done)
    `KSL_ASSERT_IMP(a_one_column, i_clk, i_rst_n, o_res.valid, $onehot(~o_res.column_drive))
    `KSL_ASSERT_NXT(a_access_steady, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.access_granted))

endmodule
